// ----- design/ppu_pkg.sv -----
package ppu_pkg;

	localparam int PALETTE_DEPTH_DEF = 256;
	localparam int MAX_WIDTH_DEF     = 4096;
	localparam int MAX_HEIGHT_DEF    = 4096;

	localparam int CFG_W   = 13;
	localparam int COORD_W = 12;

	localparam logic [1:0] OP_PALETTE = 2'd0;
	localparam logic [1:0] OP_DATA    = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	localparam logic [1:0] REG_DEPTH  = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;
	localparam logic [1:0] REG_STRIDE = 2'd3;

	localparam logic [1:0] BPP_1 = 2'd0;
	localparam logic [1:0] BPP_2 = 2'd1;
	localparam logic [1:0] BPP_4 = 2'd2;
	localparam logic [1:0] BPP_8 = 2'd3;

	typedef struct packed {
		logic [7:0]         data;
		logic [1:0]         code;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [2:0]         last_idx;
		logic               img_end;
	} ppu_load_t;

endpackage

// ----- design/ppu_palette_ram.sv -----
module ppu_palette_ram
	import ppu_pkg::*;
#(
	parameter int DEPTH = PALETTE_DEPTH_DEF,
	parameter int AW    = $clog2(PALETTE_DEPTH_DEF)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/ppu_pixel_seq.sv -----
module ppu_pixel_seq
	import ppu_pkg::*;
#(
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
	parameter int AW            = $clog2(PALETTE_DEPTH_DEF)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load_en,
	input  ppu_load_t          load,
	output logic               load_ok,
	output logic               rd_en,
	output logic [AW-1:0]      rd_addr,
	input  logic [31:0]        rd_data,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [COORD_W-1:0] pixel_x,
	output logic [COORD_W-1:0] pixel_y,
	output logic [31:0]        pixel_color,
	output logic               last_of_byte,
	output logic               last_of_image
);

	logic               s1_valid;
	logic [7:0]         s1_data;
	logic [1:0]         s1_code;
	logic [COORD_W-1:0] s1_x;
	logic [COORD_W-1:0] s1_y;
	logic [2:0]         s1_cnt;
	logic               s1_img_end;

	logic               s2_valid;
	logic [COORD_W-1:0] s2_x;
	logic [COORD_W-1:0] s2_y;
	logic               s2_lob;
	logic               s2_loi;
	logic               s2_oob;

	logic       s2_move;
	logic       issue;
	logic       s1_last;
	logic [7:0] idx;
	logic [7:0] data_next;

	always_comb begin
		unique case (s1_code)
			BPP_1: begin
				idx       = {7'd0, s1_data[7]};
				data_next = {s1_data[6:0], 1'b0};
			end
			BPP_2: begin
				idx       = {6'd0, s1_data[7:6]};
				data_next = {s1_data[5:0], 2'b0};
			end
			BPP_4: begin
				idx       = {4'd0, s1_data[7:4]};
				data_next = {s1_data[3:0], 4'b0};
			end
			default: begin
				idx       = s1_data;
				data_next = 8'd0;
			end
		endcase
	end

	assign s2_move = s2_valid && (!out_valid || !out_stall);
	assign issue   = s1_valid && (!s2_valid || s2_move);
	assign s1_last = (s1_cnt == 3'd0);
	assign load_ok = !s1_valid || (issue && s1_last);
	assign rd_en   = issue;
	assign rd_addr = idx[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid  <= 1'b0;
			s2_valid  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (load_en) begin
				s1_valid <= 1'b1;
			end else if (issue && s1_last) begin
				s1_valid <= 1'b0;
			end
			if (issue) begin
				s2_valid <= 1'b1;
			end else if (s2_move) begin
				s2_valid <= 1'b0;
			end
			if (s2_move) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			s1_data    <= load.data;
			s1_code    <= load.code;
			s1_x       <= load.x;
			s1_y       <= load.y;
			s1_cnt     <= load.last_idx;
			s1_img_end <= load.img_end;
		end else if (issue) begin
			s1_data <= data_next;
			s1_x    <= s1_x + COORD_W'(1);
			s1_cnt  <= s1_cnt - 3'd1;
		end
		if (issue) begin
			s2_x   <= s1_x;
			s2_y   <= s1_y;
			s2_lob <= s1_last;
			s2_loi <= s1_last && s1_img_end;
			s2_oob <= ({24'd0, idx} >= 32'(PALETTE_DEPTH));
		end
		if (s2_move) begin
			pixel_x       <= s2_x;
			pixel_y       <= s2_y;
			pixel_color   <= s2_oob ? 32'd0 : rd_data;
			last_of_byte  <= s2_lob;
			last_of_image <= s2_loi;
		end
	end

endmodule

// ----- design/palettized_pixel_unpacker_unit.sv -----
// Palettized pixel unpacker.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets bits per
// pixel, image width, image height and row stride; it is always ready. The user
// must write it only while the unit is idle; the unit does not enforce this.
// Input channel (in_valid/in_stall) takes one word per accepted edge: a palette
// write, an image data byte or a position restart.
// Output channel (out_valid/out_stall) gives one pixel per word: x, y, color and
// the last-of-byte and last-of-image flags.
// A data byte yields up to eight pixels, one per cycle while the output is not
// stalled, each read from the one-port-read palette RAM; the byte occupies the
// pixel sequencer until its last pixel is issued. Palette writes, restarts and
// padding bytes never enter the sequencer. The first pixel of a byte passes the
// s1 load register, the s2 palette-read register and the output register in turn.
// A stalled output holds its word; the sequencer and then in_stall back up.
// Reset clears position and pipeline state and restores the register defaults;
// palette contents stay undefined until written.
module palettized_pixel_unpacker_unit
	import ppu_pkg::*;
#(
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
	parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT    = MAX_HEIGHT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic [7:0]         palette_slot,
	input  logic [31:0]        palette_color,
	input  logic [7:0]         data_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [COORD_W-1:0] pixel_x,
	output logic [COORD_W-1:0] pixel_y,
	output logic [31:0]        pixel_color,
	output logic               last_of_byte,
	output logic               last_of_image
);

	localparam int AW     = $clog2(PALETTE_DEPTH);
	localparam int CW     = $clog2(MAX_WIDTH + 1);
	localparam int HW     = $clog2(MAX_HEIGHT + 1);
	localparam int BMAX   = (MAX_WIDTH > 8191) ? MAX_WIDTH : 8191;
	localparam int BW     = $clog2(BMAX + 2);

	logic [1:0]       depth_q;
	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [CFG_W-1:0] stride_q;

	logic [CW-1:0] col_q;
	logic [HW-1:0] row_q;
	logic [BW-1:0] bir_q;

	logic          accept;
	logic          load_ok;
	logic          load_en;
	ppu_load_t     load;
	logic          pal_we;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [31:0]   rd_data;

	logic [CW-1:0] width_c;
	logic [HW-1:0] height_c;
	logic [BW-1:0] bir_next;
	logic          stride_hit;
	logic          padding;
	logic [3:0]    per_byte;
	logic [CW-1:0] remain;
	logic [3:0]    n;
	logic [CW-1:0] col_next;
	logic [HW-1:0] row_inc;
	logic          row_wrap;
	logic          img_end;
	logic [31:0]   col_ext;
	logic [31:0]   row_ext;

	assign cfg_ready = 1'b1;
	assign in_stall  = !load_ok;
	assign accept    = in_valid && load_ok;

	always_comb begin
		if ({19'd0, width_q} > 32'(MAX_WIDTH)) begin
			width_c = CW'(MAX_WIDTH);
		end else if (width_q == '0) begin
			width_c = CW'(1);
		end else begin
			width_c = CW'(width_q);
		end
		if ({19'd0, height_q} > 32'(MAX_HEIGHT)) begin
			height_c = HW'(MAX_HEIGHT);
		end else if (height_q == '0) begin
			height_c = HW'(1);
		end else begin
			height_c = HW'(height_q);
		end
	end

	assign bir_next   = bir_q + BW'(1);
	assign stride_hit = bir_next >= {{(BW - CFG_W){1'b0}}, stride_q};
	assign padding    = col_q >= width_c;
	assign per_byte   = 4'd8 >> depth_q;
	assign remain     = width_c - col_q;
	assign n          = (remain > CW'(per_byte)) ? per_byte : remain[3:0];
	assign col_next   = col_q + CW'(n);
	assign row_inc    = row_q + HW'(1);
	assign row_wrap   = row_inc >= height_c;
	assign img_end    = row_wrap && (col_next >= width_c);
	assign col_ext    = 32'(col_q);
	assign row_ext    = 32'(row_q);

	assign load_en       = accept && (operation == OP_DATA) && !padding;
	assign load.data     = data_byte;
	assign load.code     = depth_q;
	assign load.x        = col_ext[COORD_W-1:0];
	assign load.y        = row_ext[COORD_W-1:0];
	assign load.last_idx = 3'(n - 4'd1);
	assign load.img_end  = img_end;

	assign pal_we = accept && (operation == OP_PALETTE)
		&& ({24'd0, palette_slot} < 32'(PALETTE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q  <= BPP_8;
			width_q  <= CFG_W'(1);
			height_q <= CFG_W'(1);
			stride_q <= CFG_W'(4);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEPTH:  depth_q  <= cfg_data[1:0];
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_STRIDE: stride_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			bir_q <= '0;
		end else if (accept) begin
			unique case (operation)
				OP_RESTART: begin
					col_q <= '0;
					row_q <= '0;
					bir_q <= '0;
				end
				OP_DATA: begin
					if ((padding || col_next >= width_c) && stride_hit) begin
						col_q <= '0;
						bir_q <= '0;
						row_q <= row_wrap ? '0 : row_inc;
					end else begin
						bir_q <= bir_next;
						if (!padding) begin
							col_q <= col_next;
						end
					end
				end
				default: ;
			endcase
		end
	end

	ppu_palette_ram #(
		.DEPTH (PALETTE_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (pal_we),
		.waddr (palette_slot[AW-1:0]),
		.wdata (palette_color),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	ppu_pixel_seq #(
		.PALETTE_DEPTH (PALETTE_DEPTH),
		.AW            (AW)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.load_en       (load_en),
		.load          (load),
		.load_ok       (load_ok),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.pixel_color   (pixel_color),
		.last_of_byte  (last_of_byte),
		.last_of_image (last_of_image)
	);

endmodule

// ----- tb/sv/tb.sv -----
module tb;
	import ppu_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CFG_MAX = (1 << CFG_W) - 1;
	localparam int DIM_LIMIT = 4096;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 24;
	localparam int HOLD_CYCLES = 400;
	localparam int REPORT_LIMIT = 10;
	localparam logic [15:0] CYCLIC_STALLS = 16'b1100_1011_0001_1101;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_CYCLIC, STALL_HEAVY} stall_mode_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [31:0]        color;
		logic               lob;
		logic               loi;
	} pixel_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [CFG_W-1:0]   cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         operation;
	logic [7:0]         palette_slot;
	logic [31:0]        palette_color;
	logic [7:0]         data_byte;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [COORD_W-1:0] pixel_x;
	logic [COORD_W-1:0] pixel_y;
	logic [31:0]        pixel_color;
	logic               last_of_byte;
	logic               last_of_image;

	logic [31:0]      palette_copy [256];
	logic [1:0]       depth_code;
	logic [CFG_W-1:0] width_reg;
	logic [CFG_W-1:0] height_reg;
	logic [CFG_W-1:0] stride_reg;
	int               col_pos;
	int               row_pos;
	int               row_byte;
	pixel_t           pending_pixels[$];
	pixel_t           seen_pixel;
	pixel_t           want_pixel;

	int          fail_count = 0;
	int          cycles = 0;
	int          burst_left = 0;
	bit          gaps_on = 1'b1;
	stall_mode_t stall_mode = STALL_LIGHT;
	int          hold_req = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	logic [3:0]  stall_phase = '0;

	palettized_pixel_unpacker_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.palette_slot(palette_slot),
		.palette_color(palette_color),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.pixel_color(pixel_color),
		.last_of_byte(last_of_byte),
		.last_of_image(last_of_image)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("palettized_pixel_unpacker_unit test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		stall_phase <= stall_phase + 4'd1;
		if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				STALL_NONE:   out_stall <= 1'b0;
				STALL_LIGHT:  out_stall <= ($urandom_range(0, 99) < 35);
				STALL_CYCLIC: out_stall <= CYCLIC_STALLS[stall_phase];
				default:      out_stall <= ($urandom_range(0, 99) < 80);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen_pixel.x = pixel_x;
			seen_pixel.y = pixel_y;
			seen_pixel.color = pixel_color;
			seen_pixel.lob = last_of_byte;
			seen_pixel.loi = last_of_image;
			if (pending_pixels.size() == 0) begin
				if (fail_count < REPORT_LIMIT)
					$display("unexpected pixel: x=%0d y=%0d color=%h lob=%b loi=%b",
						seen_pixel.x, seen_pixel.y, seen_pixel.color, seen_pixel.lob,
						seen_pixel.loi);
				fail_count++;
			end else begin
				want_pixel = pending_pixels.pop_front();
				if (seen_pixel !== want_pixel) begin
					if (fail_count < REPORT_LIMIT)
						$display("pixel mismatch: expected x=%0d y=%0d color=%h lob=%b loi=%b,",
							want_pixel.x, want_pixel.y, want_pixel.color, want_pixel.lob,
							want_pixel.loi, " got x=%0d y=%0d color=%h lob=%b loi=%b",
							seen_pixel.x, seen_pixel.y, seen_pixel.color,
							seen_pixel.lob, seen_pixel.loi);
					fail_count++;
				end
			end
		end
	end

	function automatic int clamp_dim(int v);
		if (v < 1)
			return 1;
		if (v > DIM_LIMIT)
			return DIM_LIMIT;
		return v;
	endfunction

	function automatic void close_row(int height);
		col_pos = 0;
		row_byte = 0;
		row_pos = (row_pos + 1 >= height) ? 0 : row_pos + 1;
	endfunction

	function automatic void unpack_word(logic [1:0] op, logic [7:0] slot, logic [31:0] color,
			logic [7:0] pix_byte);
		int width;
		int height;
		int bits;
		int per_byte;
		int count;
		int idx;
		bit img_end;
		pixel_t px;
		width = clamp_dim(int'(width_reg));
		height = clamp_dim(int'(height_reg));
		case (op)
			OP_PALETTE: palette_copy[slot] = color;
			OP_RESTART: begin
				col_pos = 0;
				row_pos = 0;
				row_byte = 0;
			end
			OP_DATA: begin
				row_byte++;
				if (col_pos >= width) begin
					if (row_byte >= int'(stride_reg))
						close_row(height);
				end else begin
					bits = 1 << depth_code;
					per_byte = 8 >> depth_code;
					count = width - col_pos;
					if (count > per_byte)
						count = per_byte;
					img_end = (row_pos + 1 >= height) && (col_pos + count >= width);
					for (int i = 0; i < count; i++) begin
						idx = (int'(pix_byte) >> (bits * (per_byte - 1 - i))) & ((1 << bits) - 1);
						px.x = COORD_W'(col_pos + i);
						px.y = COORD_W'(row_pos);
						px.color = palette_copy[idx];
						px.lob = (i == count - 1);
						px.loi = px.lob && img_end;
						pending_pixels.push_back(px);
					end
					col_pos += count;
					if (col_pos >= width && row_byte >= int'(stride_reg))
						close_row(height);
				end
			end
			default: ;
		endcase
	endfunction

	task automatic write_reg(logic [1:0] idx, int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_W-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_DEPTH:  depth_code = value[1:0];
			REG_WIDTH:  width_reg = value[CFG_W-1:0];
			REG_HEIGHT: height_reg = value[CFG_W-1:0];
			default:    stride_reg = value[CFG_W-1:0];
		endcase
	endtask

	task automatic apply_config(int depth, int width, int height, int stride);
		write_reg(REG_DEPTH, depth);
		write_reg(REG_WIDTH, width);
		write_reg(REG_HEIGHT, height);
		write_reg(REG_STRIDE, stride);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_word(logic [1:0] op, logic [7:0] slot, logic [31:0] color,
			logic [7:0] pix_byte);
		int gap;
		in_valid <= 1'b1;
		operation <= op;
		palette_slot <= slot;
		palette_color <= color;
		data_byte <= pix_byte;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		unpack_word(op, slot, color, pix_byte);
		gap = 0;
		if (gaps_on) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(0, 15);
				gap = $urandom_range(1, 9);
			end
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random_word();
		int pick;
		logic [1:0] op;
		pick = $urandom_range(0, 99);
		if (pick < 78)
			op = OP_DATA;
		else if (pick < 90)
			op = OP_PALETTE;
		else if (pick < 95)
			op = OP_RESTART;
		else
			op = OP_UNUSED;
		send_word(op, 8'($urandom_range(0, 255)), $urandom, 8'($urandom_range(0, 255)));
	endtask

	// hold input low until every pixel is out, then let the pipeline empty
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_load_palette();
		gaps_on = 1'b1;
		stall_mode = STALL_LIGHT;
		for (int s = 0; s < 256; s++)
			send_word(OP_PALETTE, 8'(s), $urandom, 8'($urandom_range(0, 255)));
		drain();
	endtask

	task automatic test_directed();
		send_word(OP_PALETTE, 8'h00, 32'h0000_0000, 8'h00);
		send_word(OP_PALETTE, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
		send_word(OP_PALETTE, 8'h01, 32'h8000_0001, 8'h00);
		// register defaults: 8 bpp, one pixel per row, one row, stride of four
		send_word(OP_DATA, 8'h00, 32'h0, 8'hFF);
		repeat (3) send_word(OP_DATA, 8'h00, 32'h0, 8'h01);
		send_word(OP_DATA, 8'h00, 32'h0, 8'h00);
		send_word(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
		send_word(OP_RESTART, 8'h00, 32'h0, 8'h00);
		send_word(OP_DATA, 8'h00, 32'h0, 8'h01);
		drain();
		apply_config(BPP_1, 13, 2, 0);
		send_word(OP_DATA, 8'h00, 32'h0, 8'h80);
		send_word(OP_DATA, 8'h00, 32'h0, 8'h01);
		send_word(OP_DATA, 8'h00, 32'h0, 8'hFF);
		send_word(OP_DATA, 8'h00, 32'h0, 8'h5A);
		drain();
		apply_config(BPP_2, 0, CFG_MAX, 3);
		send_word(OP_DATA, 8'h00, 32'h0, 8'hE4);
		repeat (2) send_word(OP_DATA, 8'h00, 32'h0, 8'h3C);
		drain();
		// row now lies past the new height
		apply_config(BPP_4, 3, 1, 2);
		send_word(OP_DATA, 8'h00, 32'h0, 8'h12);
		send_word(OP_DATA, 8'h00, 32'h0, 8'h34);
		drain();
		apply_config(BPP_8, CFG_MAX, 0, CFG_MAX);
		send_word(OP_DATA, 8'h00, 32'h0, 8'hFF);
		send_word(OP_DATA, 8'h00, 32'h0, 8'h00);
		drain();
	endtask

	task automatic test_backpressure();
		apply_config(BPP_1, 40, 3, 6);
		send_word(OP_RESTART, 8'h00, 32'h0, 8'h00);
		gaps_on = 1'b0;
		stall_mode = STALL_NONE;
		hold_req++;
		repeat (40) send_word(OP_DATA, 8'($urandom_range(0, 255)), $urandom,
			8'($urandom_range(0, 255)));
		drain();
		gaps_on = 1'b1;
		stall_mode = STALL_CYCLIC;
		repeat (30) send_random_word();
		drain();
	endtask

	task automatic random_config();
		int depth;
		int width;
		int height;
		int stride;
		int used;
		depth = $urandom_range(0, 3);
		case ($urandom_range(0, 9))
			0:       width = 0;
			1:       width = DIM_LIMIT;
			2:       width = CFG_MAX;
			default: width = $urandom_range(1, 24);
		endcase
		case ($urandom_range(0, 9))
			0:       height = 0;
			1:       height = DIM_LIMIT;
			2:       height = CFG_MAX;
			default: height = $urandom_range(1, 4);
		endcase
		used = (clamp_dim(width) * (1 << depth) + 7) / 8;
		case ($urandom_range(0, 11))
			0:       stride = 0;
			1:       stride = used;
			2:       stride = $urandom_range(0, used);
			3:       stride = CFG_MAX;
			default: stride = used + $urandom_range(1, 4);
		endcase
		apply_config(depth, width, height, stride);
	endtask

	task automatic test_random_stream();
		int words;
		for (int phase = 0; phase < 12; phase++) begin
			random_config();
			gaps_on = ($urandom_range(0, 3) != 0);
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			words = $urandom_range(6, 12);
			repeat (words) send_random_word();
			drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_DEPTH;
		cfg_data = '0;
		in_valid = 1'b0;
		operation = OP_PALETTE;
		palette_slot = '0;
		palette_color = '0;
		data_byte = '0;
		depth_code = BPP_8;
		width_reg = 1;
		height_reg = 1;
		stride_reg = 4;
		col_pos = 0;
		row_pos = 0;
		row_byte = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_load_palette();
		test_directed();
		test_backpressure();
		test_random_stream();
		drain();
		if (fail_count == 0 && pending_pixels.size() == 0)
			$display("palettized_pixel_unpacker_unit test passed");
		else
			$display("palettized_pixel_unpacker_unit test failed");
		$finish;
	end

endmodule

// ----- sim.f -----
design/ppu_pkg.sv
design/ppu_palette_ram.sv
design/ppu_pixel_seq.sv
design/palettized_pixel_unpacker_unit.sv
tb/sv/tb.sv
